/* design/tcch_pkg.sv */
// Shared constants and functions for the tilt-compensated compass heading block.
`default_nettype none
package tcch_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int TILT_SIN_Q16 = 46090;
    localparam int ACC_W = 64;
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 20;
    localparam int HEADING_FULL = 92160;

    localparam logic [9:0]  SCALE_RST  = 10'd50;
    localparam logic [8:0]  OFFSET_RST = 9'd140;
    localparam logic [15:0] WEIGHT_RST = 16'd3277;

    localparam logic [1:0] REG_SCALE  = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_WEIGHT = 2'd2;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'd536870912;   5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;   5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;    5'd5: v = 32'd21354465;
            5'd6: v = 32'd10679838;    5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;     5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;     5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;     5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;      5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;      5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;       5'd19: v = 32'd1304;
            5'd20: v = 32'd652;        5'd21: v = 32'd326;
            5'd22: v = 32'd163;        5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

/* design/tilt_compensated_compass_heading_top.sv */
// Top level: tilt-compensated compass heading with running average.
//
// Channel | Direction | tdata (low bit up)                                  | tuser
// s_      | in        | mag_x, mag_y, mag_z, accel_x, accel_y (5 x 16, 80 bits) | -
// m_      | out       | heading_out (18), zero fill to 24 bits             | tilt_error
//
// One input transfer runs a tilt check, two 20-step square roots, 9 products
// on the shared 36x20 multiplier, normalization one bit a cycle, CORDIC_STEPS
// vectoring steps, heading scale, averaging and output. A tilt error skips to
// output and leaves the average unchanged. Reset is synchronous and active low;
// it clears the average and loads the configuration registers with defaults.
// s_tready stays low until the result is taken.
`default_nettype none
module tilt_compensated_compass_heading_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // mag_x, mag_y, mag_z, accel_x, accel_y
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // heading_out[17:0]
    output logic             m_tuser,   // tilt_error
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import tcch_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TILT, S_SQRT, S_MUL, S_NORM, S_CORDIC, S_HMUL, S_DIFF, S_AMUL,
        S_DONE, S_OUT
    } state_t;

    state_t state_reg;
    logic [9:0]  scale_reg;
    logic [8:0]  offset_reg;
    logic [15:0] weight_reg;
    logic [24:0] avg_reg;
    logic signed [16:0] mx_reg, my_reg, mz_reg, ax_reg, ay_reg;
    logic [10:0] s_reg;
    // square root unit
    logic [39:0] rv_reg;
    logic [39:0] rr_reg;
    logic [39:0] rbit_reg;
    logic        rsel_reg;
    logic [18:0] cp_reg, cr_reg;
    // multiply sequencer
    logic [3:0]  mstep_reg;
    logic signed [ACC_W-1:0] p_reg, x_reg, y_reg;
    logic signed [ACC_W-1:0] cx_reg, cy_reg;
    logic [4:0]  ci_reg;
    logic [31:0] ang_reg;
    logic        err_reg;
    logic [17:0] hout_reg;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_A_W+MUL_B_W-1:0] mul_p;
    logic signed [MUL_A_W-1:0] p_op;
    logic signed [MUL_B_W-1:0] cp_op, cr_op, sp_op, sr_op, big_op;

    always_comb begin
        p_op   = $signed(p_reg[MUL_A_W-1:0]);
        cp_op  = $signed(MUL_B_W'(cp_reg));
        cr_op  = $signed(MUL_B_W'(cr_reg));
        sp_op  = -(MUL_B_W'(ay_reg) <<< 8);
        sr_op  = -(MUL_B_W'(ax_reg) <<< 8);
        big_op = $signed(MUL_B_W'({s_reg, 8'd0}));
    end

    // one shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL: begin
                case (mstep_reg)
                    4'd0: begin mul_a = MUL_A_W'(mx_reg); mul_b = cp_op; end
                    4'd1: begin mul_a = MUL_A_W'(mz_reg); mul_b = sp_op; end
                    4'd2: begin mul_a = p_op; mul_b = big_op; end
                    4'd3: begin mul_a = MUL_A_W'(mx_reg); mul_b = sr_op; end
                    4'd4: begin mul_a = p_op; mul_b = sp_op; end
                    4'd5: begin mul_a = MUL_A_W'(my_reg); mul_b = cr_op; end
                    4'd6: begin mul_a = p_op; mul_b = big_op; end
                    4'd7: begin mul_a = MUL_A_W'(mz_reg); mul_b = sr_op; end
                    default: begin mul_a = p_op; mul_b = cp_op; end
                endcase
            end
            S_HMUL: begin
                mul_a = $signed(MUL_A_W'(ang_reg));
                mul_b = MUL_B_W'(HEADING_FULL);
            end
            S_AMUL: begin mul_a = p_op; mul_b = $signed(MUL_B_W'(weight_reg)); end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    logic [31:0] sa2;
    logic [47:0] tl, tr;
    logic signed [ACC_W-1:0] ax_abs, ay_abs;
    logic [39:0] rsum;
    logic signed [ACC_W-1:0] xs, ys, xa, ya;
    logic signed [ACC_W-1:0] hd, avg_n;

    always_comb begin
        ax_abs = (ax_reg < 0) ? -ACC_W'(ax_reg) : ACC_W'(ax_reg);
        ay_abs = (ay_reg < 0) ? -ACC_W'(ay_reg) : ACC_W'(ay_reg);
        tl = 48'(ax_abs) << 16;
        tr = 48'(ay_abs) << 16;
        sa2 = 32'(s_reg) * 32'(TILT_SIN_Q16);
        rsum = rr_reg + rbit_reg;
        xs = cx_reg >>> ci_reg;
        ys = cy_reg >>> ci_reg;
        xa = (cx_reg < 0) ? -cx_reg : cx_reg;
        ya = (cy_reg < 0) ? -cy_reg : cy_reg;
        hd = $signed({24'd0, p_reg[ACC_W-1:32], 8'd0}) - $signed({39'd0, avg_reg});
        avg_n = $signed({39'd0, avg_reg}) + ((ACC_W'(mul_p) + 64'sd32768) >>> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            scale_reg  <= SCALE_RST;
            offset_reg <= OFFSET_RST;
            weight_reg <= WEIGHT_RST;
            avg_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_SCALE:  scale_reg  <= cfg_wdata[9:0];
                    REG_OFFSET: offset_reg <= cfg_wdata[8:0];
                    REG_WEIGHT: weight_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    mx_reg <= 17'($signed(s_tdata[15:0]));
                    my_reg <= 17'($signed(s_tdata[31:16]));
                    mz_reg <= 17'($signed(s_tdata[47:32]));
                    ax_reg <= 17'($signed(s_tdata[63:48]));
                    ay_reg <= 17'($signed(s_tdata[79:64]));
                    s_reg  <= (scale_reg == 10'd0) ? 11'd1 : {1'b0, scale_reg};
                    state_reg <= S_TILT;
                end
                S_TILT: begin
                    if (tl > 48'(sa2) || tr > 48'(sa2)) begin
                        err_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end else begin
                        err_reg <= 1'b0;
                        rsel_reg <= 1'b0;
                        rv_reg <= 40'((32'(s_reg) * 32'(s_reg) - 32'(ay_abs) * 32'(ay_abs))) << 16;
                        rr_reg <= '0;
                        rbit_reg <= 40'd1 << 38;
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (rbit_reg == 40'd0) begin
                        if (!rsel_reg) begin
                            cp_reg <= rr_reg[18:0];
                            rsel_reg <= 1'b1;
                            rv_reg <= 40'((32'(s_reg) * 32'(s_reg) - 32'(ax_abs) * 32'(ax_abs))) << 16;
                            rr_reg <= '0;
                            rbit_reg <= 40'd1 << 38;
                        end else begin
                            cr_reg <= rr_reg[18:0];
                            mstep_reg <= '0;
                            state_reg <= S_MUL;
                        end
                    end else begin
                        if (rv_reg >= rsum) begin
                            rv_reg <= rv_reg - rsum;
                            rr_reg <= (rr_reg >> 1) + rbit_reg;
                        end else
                            rr_reg <= rr_reg >> 1;
                        rbit_reg <= rbit_reg >> 2;
                    end
                end
                S_MUL: begin
                    mstep_reg <= mstep_reg + 4'd1;
                    case (mstep_reg)
                        4'd0: p_reg <= ACC_W'(mul_p);
                        4'd1: p_reg <= p_reg + ACC_W'(mul_p);
                        4'd2: x_reg <= ACC_W'(mul_p);
                        4'd3: p_reg <= ACC_W'(mul_p);
                        4'd4: y_reg <= ACC_W'(mul_p);
                        4'd5: p_reg <= ACC_W'(mul_p);
                        4'd6: y_reg <= y_reg + ACC_W'(mul_p);
                        4'd7: p_reg <= ACC_W'(mul_p);
                        default: begin
                            // finish y = ... - mz*sr*cp, as (mz*sr)*cp
                            cx_reg <= x_reg;
                            cy_reg <= y_reg - ACC_W'(mul_p);
                            ang_reg <= '0;
                            state_reg <= S_NORM;
                        end
                    endcase
                end
                S_NORM: begin
                    if (cx_reg == 0 && cy_reg == 0) begin
                        ang_reg <= '0;
                        state_reg <= S_HMUL;
                    end else if (xa >= 64'sd1073741824 || ya >= 64'sd1073741824) begin
                        cx_reg <= cx_reg / 2;
                        cy_reg <= cy_reg / 2;
                    end else if (xa < 64'sd536870912 && ya < 64'sd536870912) begin
                        cx_reg <= cx_reg <<< 1;
                        cy_reg <= cy_reg <<< 1;
                    end else begin
                        if (cx_reg < 0) begin
                            cx_reg <= -cx_reg;
                            cy_reg <= -cy_reg;
                            ang_reg <= 32'h8000_0000;
                        end
                        ci_reg <= '0;
                        state_reg <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    if (cy_reg >= 0) begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        ang_reg <= ang_reg + atan_entry(ci_reg);
                    end else begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        ang_reg <= ang_reg - atan_entry(ci_reg);
                    end
                    ci_reg <= ci_reg + 5'd1;
                    if (ci_reg == 5'(CORDIC_STEPS - 1)) state_reg <= S_HMUL;
                end
                S_HMUL: begin
                    p_reg <= ACC_W'(mul_p) + 64'sd2147483648;
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    p_reg <= hd;
                    state_reg <= S_AMUL;
                end
                S_AMUL: begin
                    avg_reg <= 25'(avg_n);
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    hout_reg <= 18'((($signed({39'd0, avg_reg}) + 64'sd128) >>> 8)
                                    - $signed({47'd0, offset_reg, 8'd0}));
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {6'd0, hout_reg};
    assign m_tuser  = err_reg;
endmodule
`default_nettype wire
